@@ hw/rtl/ppu_pkg.sv @@
// Shared constants, codes and the particle slot layout of the particle pool.
package ppu_pkg;

   localparam int POOL_SIZE = 1024;
   localparam int ADDR_W    = $clog2(POOL_SIZE);

   // Item kinds.
   localparam logic [1:0] FUNC_EMIT = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // Control register indexes.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_SPREAD_X    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_SPREAD_Y    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_START_BASE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_SPREAD     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_FINAL      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFE_SPAN       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_START     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_FINAL     = 4'd7;

   localparam logic [18:0]        TWO_PI_Q16   = 19'd411775;
   localparam logic signed [16:0] HALF_Q16     = 17'sd32768;
   // floor(x/100) == (x * DIV100_RECIP) >> DIV100_SHIFT for every 17-bit x.
   localparam logic [17:0]        DIV100_RECIP = 18'd167773;
   localparam int                 DIV100_SHIFT = 24;
   localparam logic [16:0]        FRAC_ONE     = 17'd65536;
   localparam int                 FRAC_BITS    = 16;

   typedef struct packed {
      logic              active;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] angle;
      logic [30:0]        birth_size;
      logic signed [31:0] life;
   } ppu_slot_type;

   localparam int SLOT_W = $bits(ppu_slot_type);

endpackage

@@ hw/rtl/ppu_ifs.sv @@
// Handshake channels of the particle pool: item input, result output, control writes.
interface ppu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] spawn_x;
   logic signed [31:0] spawn_y;
   logic signed [31:0] base_vel_x;
   logic signed [31:0] base_vel_y;
   logic [15:0]        rand_angle;
   logic [15:0]        rand_vel_x;
   logic [15:0]        rand_vel_y;
   logic [15:0]        rand_size;
   logic [16:0]        step_time;
   logic [9:0]         slot_index;

   modport source (output valid, func, spawn_x, spawn_y, base_vel_x, base_vel_y, rand_angle,
                   rand_vel_x, rand_vel_y, rand_size, step_time, slot_index, input ready);
   modport sink (input valid, func, spawn_x, spawn_y, base_vel_x, base_vel_y, rand_angle,
                 rand_vel_x, rand_vel_y, rand_size, step_time, slot_index, output ready);
endinterface

interface ppu_rsp_if;
   logic               valid;
   logic               ready;
   logic               alive;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_angle;
   logic [30:0]        out_size;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   logic [7:0]         alpha;

   modport source (output valid, alive, out_x, out_y, out_angle, out_size, red, green, blue,
                   alpha, input ready);
   modport sink (input valid, alive, out_x, out_y, out_angle, out_size, red, green, blue,
                 alpha, output ready);
endinterface

interface ppu_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ppu_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ppu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hw/rtl/particle_pool_update.sv @@
// Emit multiplies, then writes the slot. Read goes address, data, the 16-step divider when the life
// fraction needs it, multiply, lerp, alpha to a valid result. Tick walks the slot RAM once.
// One item is worked on at a time; the slot RAM port (one slot per cycle) sets tick rate.
// A finished result waits in an output register while the next item is taken.
// Reset is synchronous; afterwards a clearing pass zeroes every slot of the slot
// RAM and no item is taken during it (control writes are taken throughout).
module particle_pool_update (
   input  logic clock,
   input  logic reset,
   ppu_req_if.sink   req_bus,
   ppu_rsp_if.source rsp_bus,
   ppu_csr_if.sink   csr_bus
);
   import ppu_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EMIT_MUL, S_EMIT_WR, S_TICK_PREP, S_TICK,
      S_RD_ADDR, S_RD_DATA, S_RD_DIV, S_RD_MUL, S_RD_LERP, S_RD_ALPHA
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) return 32'sh7fffffff;
      else if (v < -36'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   // Control registers.
   logic [30:0] vel_spread_x_ff, vel_spread_y_ff, size_start_base_ff, size_spread_ff;
   logic [30:0] size_final_ff, life_span_ff;
   logic [31:0] color_start_ff, color_final_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_spread_x_ff    <= '0;
         vel_spread_y_ff    <= '0;
         size_start_base_ff <= 31'd65536;
         size_spread_ff     <= '0;
         size_final_ff      <= '0;
         life_span_ff       <= 31'd65536;
         color_start_ff     <= 32'hffffffff;
         color_final_ff     <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_VEL_SPREAD_X:    vel_spread_x_ff    <= csr_bus.data[30:0];
            CSR_VEL_SPREAD_Y:    vel_spread_y_ff    <= csr_bus.data[30:0];
            CSR_SIZE_START_BASE: size_start_base_ff <= csr_bus.data[30:0];
            CSR_SIZE_SPREAD:     size_spread_ff     <= csr_bus.data[30:0];
            CSR_SIZE_FINAL:      size_final_ff      <= csr_bus.data[30:0];
            CSR_LIFE_SPAN:       life_span_ff       <= csr_bus.data[30:0];
            CSR_COLOR_START:     color_start_ff     <= csr_bus.data;
            CSR_COLOR_FINAL:     color_final_ff     <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Slot RAM.
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
   ppu_slot_type             ram_wdata, ram_rdata;

   ppu_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SIZE)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   state_type state_ff;
   logic [ADDR_W-1:0] write_slot_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   // Captured item.
   logic signed [31:0] spawn_x_ff, spawn_y_ff, base_vel_x_ff, base_vel_y_ff;
   logic [15:0] rand_angle_ff, rand_vel_x_ff, rand_vel_y_ff, rand_size_ff;
   logic [16:0] step_time_ff;
   logic [9:0]  slot_index_ff;

   // Emit datapath.
   logic signed [48:0] emit_vx_ff, emit_vy_ff, emit_sz_ff;
   logic [18:0]        emit_ang_ff;
   logic signed [16:0] rnd_vx_c, rnd_vy_c, rnd_sz_c;
   logic [34:0]        ang_prod_c;
   logic signed [35:0] vx_sum_c, vy_sum_c, sz_sum_c;
   logic [30:0]        sz_clamp_c;

   assign rnd_vx_c   = $signed({1'b0, rand_vel_x_ff}) - HALF_Q16;
   assign rnd_vy_c   = $signed({1'b0, rand_vel_y_ff}) - HALF_Q16;
   assign rnd_sz_c   = $signed({1'b0, rand_size_ff}) - HALF_Q16;
   assign ang_prod_c = 35'(rand_angle_ff) * 35'(TWO_PI_Q16);
   assign vx_sum_c   = 36'(base_vel_x_ff) + 36'($signed(emit_vx_ff[48:16]));
   assign vy_sum_c   = 36'(base_vel_y_ff) + 36'($signed(emit_vy_ff[48:16]));
   assign sz_sum_c   = 36'($signed({1'b0, size_start_base_ff}))
                     + 36'($signed(emit_sz_ff[48:16]));

   always_comb begin
      if (sz_sum_c < 36'sd0) sz_clamp_c = '0;
      else if (sz_sum_c > 36'sd2147483647) sz_clamp_c = 31'h7fffffff;
      else sz_clamp_c = sz_sum_c[30:0];
   end

   // Tick pipeline: read, multiply, write back.
   logic [ADDR_W:0]    tick_cnt_ff;
   logic               tv1_ff, tv2_ff;
   logic [ADDR_W-1:0]  ta1_ff, ta2_ff;
   ppu_slot_type       tw2_ff;
   logic signed [49:0] tpx_ff, tpy_ff;
   logic [10:0]        ang_inc_ff;
   logic [34:0]        inc_prod_c;
   logic               tick_issue_c;
   ppu_slot_type       tick_wr_c;

   assign inc_prod_c   = 35'(step_time_ff) * 35'(DIV100_RECIP);
   assign tick_issue_c = (state_ff == S_TICK) && (tick_cnt_ff < (ADDR_W+1)'(POOL_SIZE));

   always_comb begin
      tick_wr_c = tw2_ff;
      if (tw2_ff.life <= 32'sd0) begin
         tick_wr_c.active = 1'b0;
      end else begin
         tick_wr_c.life  = sat32(36'(tw2_ff.life) - 36'($signed({1'b0, step_time_ff})));
         tick_wr_c.pos_x = sat32(36'(tw2_ff.pos_x) + 36'($signed(tpx_ff[49:16])));
         tick_wr_c.pos_y = sat32(36'(tw2_ff.pos_y) + 36'($signed(tpy_ff[49:16])));
         tick_wr_c.angle = sat32(36'(tw2_ff.angle) + 36'($signed({1'b0, ang_inc_ff})));
      end
   end

   // Read path.
   ppu_slot_type       rdw_ff;
   logic               alive_ff;
   logic [30:0]        rem_ff;
   logic [16:0]        frac_ff;
   logic [3:0]         div_cnt_ff;
   logic signed [50:0] size_prod_ff;
   logic signed [26:0] chan_prod_ff [4];
   logic [30:0]        size_res_ff;
   logic [7:0]         chan_ff [4];
   logic [31:0]        rem2_c;
   logic               rem_ge_c;
   logic               slot_oob_c;
   logic signed [35:0] size_sum_c;
   logic [24:0]        alpha_prod_c;
   logic               rsp_free_c;

   assign rem2_c       = {rem_ff, 1'b0};
   assign rem_ge_c     = rem2_c >= {1'b0, life_span_ff};
   assign slot_oob_c   = 32'(slot_index_ff) >= 32'(POOL_SIZE);
   assign size_sum_c   = 36'($signed({1'b0, size_final_ff}))
                       + 36'($signed(size_prod_ff[50:16]));
   assign alpha_prod_c = 25'(chan_ff[3]) * 25'(frac_ff);

   // Result register.
   logic               rsp_valid_ff, rsp_alive_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_angle_ff;
   logic [30:0]        rsp_size_ff;
   logic [7:0]         rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;

   assign rsp_free_c = !rsp_valid_ff || rsp_bus.ready;

   // RAM port control.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = write_slot_ff;
      ram_wdata = '0;
      ram_raddr = ADDR_W'(slot_index_ff);
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
         end
         S_EMIT_WR: begin
            ram_we               = 1'b1;
            ram_wdata.active     = 1'b1;
            ram_wdata.pos_x      = spawn_x_ff;
            ram_wdata.pos_y      = spawn_y_ff;
            ram_wdata.vel_x      = sat32(vx_sum_c);
            ram_wdata.vel_y      = sat32(vy_sum_c);
            ram_wdata.angle      = $signed({13'd0, emit_ang_ff});
            ram_wdata.birth_size = sz_clamp_c;
            ram_wdata.life       = $signed({1'b0, life_span_ff});
         end
         S_TICK: begin
            ram_raddr = tick_cnt_ff[ADDR_W-1:0];
            ram_we    = tv2_ff && tw2_ff.active;
            ram_waddr = ta2_ff;
            ram_wdata = tick_wr_c;
         end
         default: ;
      endcase
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         write_slot_ff <= ADDR_W'(POOL_SIZE - 1);
         tv1_ff        <= 1'b0;
         tv2_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the last read state the result register is reloaded below instead.
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_RD_ALPHA) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_W'(POOL_SIZE - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               spawn_x_ff    <= req_bus.spawn_x;
               spawn_y_ff    <= req_bus.spawn_y;
               base_vel_x_ff <= req_bus.base_vel_x;
               base_vel_y_ff <= req_bus.base_vel_y;
               rand_angle_ff <= req_bus.rand_angle;
               rand_vel_x_ff <= req_bus.rand_vel_x;
               rand_vel_y_ff <= req_bus.rand_vel_y;
               rand_size_ff  <= req_bus.rand_size;
               step_time_ff  <= req_bus.step_time;
               slot_index_ff <= req_bus.slot_index;
               if (req_bus.valid) begin
                  unique case (req_bus.func)
                     FUNC_EMIT: state_ff <= S_EMIT_MUL;
                     FUNC_TICK: state_ff <= S_TICK_PREP;
                     FUNC_READ: state_ff <= S_RD_ADDR;
                     default:   state_ff <= S_IDLE;
                  endcase
               end
            end
            S_EMIT_MUL: begin
               emit_vx_ff  <= $signed({1'b0, vel_spread_x_ff}) * rnd_vx_c;
               emit_vy_ff  <= $signed({1'b0, vel_spread_y_ff}) * rnd_vy_c;
               emit_sz_ff  <= $signed({1'b0, size_spread_ff}) * rnd_sz_c;
               emit_ang_ff <= ang_prod_c[34:16];
               state_ff    <= S_EMIT_WR;
            end
            S_EMIT_WR: begin
               write_slot_ff <= (write_slot_ff == '0) ? ADDR_W'(POOL_SIZE - 1)
                                                      : write_slot_ff - 1'b1;
               state_ff <= S_IDLE;
            end
            S_TICK_PREP: begin
               ang_inc_ff  <= inc_prod_c[DIV100_SHIFT+10:DIV100_SHIFT];
               tick_cnt_ff <= '0;
               tv1_ff      <= 1'b0;
               tv2_ff      <= 1'b0;
               state_ff    <= S_TICK;
            end
            S_TICK: begin
               if (tick_issue_c) begin
                  tick_cnt_ff <= tick_cnt_ff + 1'b1;
               end
               tv1_ff <= tick_issue_c;
               ta1_ff <= tick_cnt_ff[ADDR_W-1:0];
               tv2_ff <= tv1_ff;
               ta2_ff <= ta1_ff;
               tw2_ff <= ram_rdata;
               tpx_ff <= ram_rdata.vel_x * $signed({1'b0, step_time_ff});
               tpy_ff <= ram_rdata.vel_y * $signed({1'b0, step_time_ff});
               if (!tick_issue_c && !tv1_ff && !tv2_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_RD_ADDR: begin
               state_ff <= S_RD_DATA;
            end
            S_RD_DATA: begin
               rdw_ff     <= ram_rdata;
               alive_ff   <= ram_rdata.active && !slot_oob_c;
               rem_ff     <= ram_rdata.life[30:0];
               div_cnt_ff <= '0;
               if (ram_rdata.life <= 32'sd0) begin
                  frac_ff  <= '0;
                  state_ff <= S_RD_MUL;
               end else if (life_span_ff == '0 || ram_rdata.life[30:0] >= life_span_ff) begin
                  frac_ff  <= FRAC_ONE;
                  state_ff <= S_RD_MUL;
               end else begin
                  frac_ff  <= '0;
                  state_ff <= S_RD_DIV;
               end
            end
            S_RD_DIV: begin
               // Restoring division, one quotient bit per cycle.
               rem_ff     <= rem_ge_c ? 31'(rem2_c - {1'b0, life_span_ff}) : rem2_c[30:0];
               frac_ff    <= {frac_ff[15:0], rem_ge_c};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 4'(FRAC_BITS - 1)) begin
                  state_ff <= S_RD_MUL;
               end
            end
            S_RD_MUL: begin
               size_prod_ff <= ($signed({2'b0, rdw_ff.birth_size})
                               - $signed({2'b0, size_final_ff}))
                               * $signed({1'b0, frac_ff});
               for (int k = 0; k < 4; k++) begin
                  chan_prod_ff[k] <= ($signed({1'b0, color_start_ff[31-8*k -: 8]})
                                     - $signed({1'b0, color_final_ff[31-8*k -: 8]}))
                                     * $signed({1'b0, frac_ff});
               end
               state_ff <= S_RD_LERP;
            end
            S_RD_LERP: begin
               size_res_ff <= size_sum_c[30:0];
               for (int k = 0; k < 4; k++) begin
                  chan_ff[k] <= 8'(12'($signed({1'b0, color_final_ff[31-8*k -: 8]}))
                                 + 12'($signed(chan_prod_ff[k][26:16])));
               end
               state_ff <= S_RD_ALPHA;
            end
            S_RD_ALPHA: begin
               if (rsp_free_c) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_alive_ff <= alive_ff;
                  rsp_x_ff     <= alive_ff ? rdw_ff.pos_x : '0;
                  rsp_y_ff     <= alive_ff ? rdw_ff.pos_y : '0;
                  rsp_angle_ff <= alive_ff ? rdw_ff.angle : '0;
                  rsp_size_ff  <= alive_ff ? size_res_ff : '0;
                  rsp_red_ff   <= alive_ff ? chan_ff[0] : '0;
                  rsp_green_ff <= alive_ff ? chan_ff[1] : '0;
                  rsp_blue_ff  <= alive_ff ? chan_ff[2] : '0;
                  rsp_alpha_ff <= alive_ff ? alpha_prod_c[23:16] : '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.alive     = rsp_alive_ff;
   assign rsp_bus.out_x     = rsp_x_ff;
   assign rsp_bus.out_y     = rsp_y_ff;
   assign rsp_bus.out_angle = rsp_angle_ff;
   assign rsp_bus.out_size  = rsp_size_ff;
   assign rsp_bus.red       = rsp_red_ff;
   assign rsp_bus.green     = rsp_green_ff;
   assign rsp_bus.blue      = rsp_blue_ff;
   assign rsp_bus.alpha     = rsp_alpha_ff;

endmodule

@@ hw/rtl/ppu_checker.sv @@
// Port-level checks on the particle pool, bound to the top level.
module ppu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_alive,
   input logic signed [31:0] out_x,
   input logic signed [31:0] out_y,
   input logic signed [31:0] out_angle,
   input logic [30:0]        out_size,
   input logic [7:0]         red,
   input logic [7:0]         green,
   input logic [7:0]         blue,
   input logic [7:0]         alpha
);
   // The clearing pass holds off items right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item channel ready during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_x) && $stable(out_size) && $stable(alpha))
      else $error("result beat changed while stalled");

   // A dead slot reports nothing but zeros.
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alive |-> out_x == 0 && out_y == 0 && out_angle == 0 &&
      out_size == 0 && red == 0 && green == 0 && blue == 0 && alpha == 0)
      else $error("inactive slot returned nonzero fields");
endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_alive (rsp_bus.alive),
   .out_x     (rsp_bus.out_x),
   .out_y     (rsp_bus.out_y),
   .out_angle (rsp_bus.out_angle),
   .out_size  (rsp_bus.out_size),
   .red       (rsp_bus.red),
   .green     (rsp_bus.green),
   .blue      (rsp_bus.blue),
   .alpha     (rsp_bus.alpha)
);
